>>> rtl/mcs_pkg.sv
// Shared constants and types for the min/max contrast stretch block.
// Used by mcs_front, mcs_fifo, mcs_back and the top level; depends on nothing else.

package mcs_pkg;

    localparam int PIX_W      = 24;
    localparam int MAX_PIXELS = 65536;
    localparam int ADDR_W     = $clog2(MAX_PIXELS);
    localparam int CNT_W      = ADDR_W + 1;

    // Output scale: pixels map onto 0..SCALE.
    localparam int SCALE      = 255;
    localparam int Q_BITS     = 8;
    localparam int STEP_W     = $clog2(Q_BITS);

    // Numerator 2*SCALE*diff + span and denominator 2*span.
    localparam int NUM_W      = PIX_W + 10;
    localparam int DEN_W      = PIX_W + 1;

    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);
    localparam int Q_CW       = Q_AW + 1;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EMIT = 1'b1;

    // One pixel ready for scaling: offset above the frame minimum, frame range.
    typedef struct packed {
        logic [PIX_W-1:0] diff;
        logic [PIX_W-1:0] span;
        logic             last;
    } job_t;

    typedef struct packed {
        logic push;
        job_t job;
    } push_t;

endpackage

>>> rtl/mcs_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.

module mcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/mcs_front.sv
// Front end: accepts words, writes loads to the frame store, tracks min and max,
// and turns emits into scaling jobs for the queue. Depends on mcs_pkg and mcs_ram.

module mcs_front
    import mcs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    in_func,
    input  logic signed [PIX_W-1:0] in_pixel,
    input  logic [Q_CW-1:0]         qcount,
    output push_t                   push
);

    logic [CNT_W-1:0]        count_reg, count_next;
    logic [ADDR_W-1:0]       idx_reg, idx_next;
    logic                    reading_reg, reading_next;
    logic signed [PIX_W-1:0] min_reg, min_next;
    logic signed [PIX_W-1:0] max_reg, max_next;
    logic                    pend_reg, pend_next;
    logic signed [PIX_W-1:0] pend_min_reg, pend_min_next;
    logic [PIX_W-1:0]        pend_span_reg, pend_span_next;
    logic                    pend_last_reg, pend_last_next;

    logic                    accept;
    logic [CNT_W-1:0]        eff_count;
    logic                    full;
    logic                    last;
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_addr;
    logic [PIX_W-1:0]        ram_rdata;
    logic signed [PIX_W:0]   span_wide;
    logic signed [PIX_W:0]   diff_wide;

    // A pending emit is not yet in the queue count, so count its slot as used.
    assign in_ready  = (qcount + Q_CW'(pend_reg)) < Q_CW'(Q_DEPTH);
    assign accept    = in_valid && in_ready;
    assign eff_count = reading_reg ? '0 : count_reg;
    assign full      = (eff_count == CNT_W'(MAX_PIXELS));
    assign last      = (CNT_W'(idx_reg) + CNT_W'(1)) >= count_reg;
    assign ram_we    = accept && (in_func == FUNC_LOAD) && !full;
    assign ram_addr  = ram_we ? eff_count[ADDR_W-1:0] : idx_reg;
    assign span_wide = {max_reg[PIX_W-1], max_reg} - {min_reg[PIX_W-1], min_reg};

    mcs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_PIXELS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (in_pixel),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        reading_next   = reading_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        pend_next      = 1'b0;
        pend_min_next  = pend_min_reg;
        pend_span_next = pend_span_reg;
        pend_last_next = pend_last_reg;

        if (accept && (in_func == FUNC_LOAD))
        begin
            // A load during readout abandons it and starts a fresh frame.
            if (reading_reg)
            begin
                count_next   = '0;
                idx_next     = '0;
                reading_next = 1'b0;
            end
            if (!full)
            begin
                count_next = eff_count + CNT_W'(1);
                if (eff_count == '0)
                begin
                    min_next = in_pixel;
                    max_next = in_pixel;
                end
                else
                begin
                    if (in_pixel < min_reg)
                    begin
                        min_next = in_pixel;
                    end
                    if (in_pixel > max_reg)
                    begin
                        max_next = in_pixel;
                    end
                end
            end
        end
        else if (accept && (in_func == FUNC_EMIT) && (count_reg != '0))
        begin
            pend_next      = 1'b1;
            pend_min_next  = min_reg;
            pend_span_next = span_wide[PIX_W-1:0];
            pend_last_next = last;
            if (last)
            begin
                count_next   = '0;
                idx_next     = '0;
                reading_next = 1'b0;
            end
            else
            begin
                idx_next     = idx_reg + ADDR_W'(1);
                reading_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            idx_reg     <= '0;
            reading_reg <= 1'b0;
            min_reg     <= '0;
            max_reg     <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            reading_reg <= reading_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_min_reg  <= pend_min_next;
        pend_span_reg <= pend_span_next;
        pend_last_reg <= pend_last_next;
    end

    // Stored pixels always lie inside [min, max], so the offset is non-negative.
    assign diff_wide     = $signed({ram_rdata[PIX_W-1], ram_rdata})
                         - {pend_min_reg[PIX_W-1], pend_min_reg};
    assign push.push     = pend_reg;
    assign push.job.diff = diff_wide[PIX_W-1:0];
    assign push.job.span = pend_span_reg;
    assign push.job.last = pend_last_reg;

endmodule

>>> rtl/mcs_fifo.sv
// Short job queue between the front end and the scaling back end.
// Depends on mcs_pkg.

module mcs_fifo
    import mcs_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  push_t           push,
    input  logic            pop,
    output job_t            head,
    output logic [Q_CW-1:0] count
);

    job_t            mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_CW-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            end
            count_reg <= count_reg + Q_CW'(push.push) - Q_CW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            mem_reg[wr_ptr_reg] <= push.job;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

>>> rtl/mcs_back.sv
// Back end: scales one pixel at a time with a restoring divider, one quotient
// bit per cycle, and holds the result in the output register. Depends on mcs_pkg.

module mcs_back
    import mcs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [Q_CW-1:0]   qcount,
    input  job_t              head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [Q_BITS-1:0] out_pixel,
    output logic              out_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  dsh_reg, dsh_next;
    logic [Q_BITS-1:0] quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              last_reg, last_next;
    logic              flat_reg, flat_next;
    logic              out_valid_reg, out_valid_next;
    logic [Q_BITS-1:0] out_pixel_reg, out_pixel_next;
    logic              out_last_reg, out_last_next;

    logic [NUM_W-1:0]  num;
    logic [DEN_W-1:0]  den;
    logic              ge;

    // round(diff*SCALE/span) with halves up is floor((2*SCALE*diff + span) / (2*span)).
    assign num = NUM_W'(head.diff) * NUM_W'(2 * SCALE) + NUM_W'(head.span);
    assign den = {head.span, 1'b0};
    assign ge  = rem_reg >= dsh_reg;

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        last_next      = last_reg;
        flat_next      = flat_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_pixel_next = out_pixel_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (qcount != '0)
                begin
                    pop        = 1'b1;
                    rem_next   = num;
                    dsh_next   = NUM_W'(den) << (Q_BITS - 1);
                    quo_next   = '0;
                    step_next  = STEP_W'(Q_BITS - 1);
                    last_next  = head.last;
                    flat_next  = (head.span == '0);
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (ge)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                quo_next = {quo_reg[Q_BITS-2:0], ge};
                dsh_next = dsh_reg >> 1;
                if (step_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    // A flat frame has no range to divide by and maps to zero.
                    out_pixel_next = flat_reg ? '0 : quo_reg;
                    out_last_next  = last_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        dsh_reg       <= dsh_next;
        quo_reg       <= quo_next;
        step_reg      <= step_next;
        last_reg      <= last_next;
        flat_reg      <= flat_next;
        out_pixel_reg <= out_pixel_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_last  = out_last_reg;

endmodule

>>> rtl/minmax_contrast_stretch.sv
// Top level of the min/max contrast stretch block.
// Depends on mcs_pkg, mcs_front, mcs_fifo and mcs_back.

// Load words (tuser 0) store one signed Q15.8 pixel per cycle into a 64K-entry
// frame store and track the frame minimum and maximum; loads past 65536 pixels
// are dropped, and a load during readout starts a new frame. Emit words
// (tuser 1) read the stored pixels back in order and return
// round((p - min) * 255 / (max - min)) on the master side, with tlast on the
// final pixel, after which the frame is empty; a flat frame gives zeros and an
// emit with nothing stored gives no word. Loads are taken every cycle while the
// job queue has room; a full queue holds off loads and emits alike. Each
// emitted pixel goes through the scaling unit as a load, 8 divider steps and a
// hand-off to the output register, one pixel at a time; a 4-entry job queue
// lets the front side run ahead of the divider.

module minmax_contrast_stretch
    import mcs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [PIX_W-1:0] s_axis_tdata,   // [23:0] pixel_value
    input  logic [0:0]       s_axis_tuser,   // [0] func
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] pixel_out
    output logic             m_axis_tlast
);

    push_t           push;
    job_t            head;
    logic            pop;
    logic [Q_CW-1:0] qcount;

    mcs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_func  (s_axis_tuser[0]),
        .in_pixel (s_axis_tdata),
        .qcount   (qcount),
        .push     (push)
    );

    mcs_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .count (qcount)
    );

    mcs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qcount    (qcount),
        .head      (head),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_pixel (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

>>> rtl/mcs_checker.sv
// Port-level checks for minmax_contrast_stretch, attached by the bind below.
// Depends only on the top level's ports.

module mcs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast
);

    // The output register is empty while reset is applied.
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("output word valid during reset");

    // Nothing has been accepted right after reset, so no word can follow at once.
    a_no_early_word: assert property (@(posedge clk)
        $rose(rst_n) |=> !m_axis_tvalid ##1 !m_axis_tvalid)
        else $error("output word appeared before any emit could finish");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output word changed");

endmodule

bind minmax_contrast_stretch mcs_checker u_mcs_checker (.*);
